/* rtl/stdpwu_pkg.sv */
// stdpwu_pkg: types, register codes, pipeline stage map and exp2 root table
// for the stdp weight update pipeline. No dependencies.
`default_nettype none

package stdpwu_pkg;

	localparam int FRAC = 24;
	localparam int NORM_SHIFT = 30 - FRAC;
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

	localparam logic [2:0] REG_TIMING_GAP = 3'd0;
	localparam logic [2:0] REG_DEP_TAU    = 3'd1;
	localparam logic [2:0] REG_POT_TAU    = 3'd2;
	localparam logic [2:0] REG_DEP_AMP    = 3'd3;
	localparam logic [2:0] REG_POT_AMP    = 3'd4;
	localparam logic [2:0] REG_MAX_WEIGHT = 3'd5;
	localparam logic [2:0] REG_DEP_MU     = 3'd6;
	localparam logic [2:0] REG_POT_MU     = 3'd7;

	// stage map: stage k turns register k into register k+1
	localparam int ST_PREP    = 0;
	localparam int ST_EOVF    = 1;
	localparam int PDIV_FIRST = 1;
	localparam int PDIV_N     = 32 + FRAC;
	localparam int EDIV_FIRST = 2;
	localparam int EDIV_N     = 31;
	localparam int ST_EPREP   = EDIV_FIRST + EDIV_N;
	localparam int EMUL_FIRST = ST_EPREP + 1;
	localparam int ST_ESHIFT  = EMUL_FIRST + FRAC;
	localparam int ST_AE      = ST_ESHIFT + 1;
	localparam int ST_LNORM   = PDIV_FIRST + PDIV_N;
	localparam int LSQ_FIRST  = ST_LNORM + 1;
	localparam int ST_LMUL    = LSQ_FIRST + FRAC;
	localparam int ST_PPREP   = ST_LMUL + 1;
	localparam int PMUL_FIRST = ST_PPREP + 1;
	localparam int ST_PSHIFT  = PMUL_FIRST + FRAC;
	localparam int ST_DWLO    = ST_PSHIFT + 1;
	localparam int ST_DWHI    = ST_DWLO + 1;
	localparam int ST_SCALE   = ST_DWHI + 1;
	localparam int ST_NMUL    = ST_SCALE + 1;
	localparam int ST_FINAL   = ST_NMUL + 1;
	localparam int N_STAGES   = ST_FINAL + 1;

	typedef struct packed {
		logic signed [31:0] weight_in;
		logic signed [31:0] interval;
		logic               is_inhibitory;
	} in_t;

	typedef struct packed {
		logic signed [31:0] weight_out;
		logic               was_changed;
		logic               was_clipped;
	} out_t;

	typedef struct packed {
		logic [30:0]        timing_gap;
		logic [30:0]        dep_tau;
		logic [30:0]        pot_tau;
		logic signed [31:0] dep_amp;
		logic signed [31:0] pot_amp;
		logic [30:0]        max_weight;
		logic [30:0]        dep_mu;
		logic [30:0]        pot_mu;
	} cfg_t;

	typedef struct packed {
		in_t         item;
		logic        gap;
		logic        dneg;
		logic [31:0] wmag;
		logic [30:0] mu;
		logic        amp_neg;
		logic [31:0] amag;
		logic [62:0] e_num;
		logic        e_ovf;
		logic [36:0] e_r;
		logic [30:0] e_nq;
		logic [30:0] p_r;
		logic [55:0] p_nq;
		logic [30:0] x_acc;
		logic [23:0] x_f;
		logic [7:0]  x_rsh;
		logic [24:0] expv;
		logic [32:0] ae;
		logic        r_zero;
		logic [5:0]  l_msb;
		logic [30:0] l_m;
		logic [23:0] l_frac;
		logic [59:0] l_prod;
		logic        l_neg;
		logic [30:0] y_acc;
		logic [23:0] y_f;
		logic [7:0]  y_sh;
		logic        y_lsh;
		logic        y_sat;
		logic [62:0] powv;
		logic [64:0] dw_lo;
		logic [63:0] dw_hi;
		logic [38:0] smag;
		logic        s_zero;
		logic        s_neg;
		logic [51:0] n_lo;
		logic [50:0] n_hi;
		out_t        res;
	} pipe_t;

	typedef logic [FRAC:0][31:0] coef_tab_t;

	function automatic logic [31:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v = v_in;
		res = '0;
		for (int i = 31; i >= 0; i--) begin
			b = 64'(1) << (2 * i);
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
		end
		return res[31:0];
	endfunction

	// c[0] = 2.0 in Q30, each next entry the square root of the one before
	function automatic coef_tab_t exp_coef_tab();
		coef_tab_t t;
		logic [63:0] c;
		c = 64'h8000_0000;
		t[0] = c[31:0];
		for (int k = 1; k <= FRAC; k++) begin
			c = {32'b0, isqrt64(c << 30)};
			t[k] = c[31:0];
		end
		return t;
	endfunction

	localparam coef_tab_t EXP_C = exp_coef_tab();

endpackage

`default_nettype wire

/* rtl/stdp_weight_update_top.sv */
// stdp_weight_update_top: pipelined multiplicative stdp weight update.
// Depends on stdpwu_pkg (types, stage map, exp2 root table).
//
//  channel  | signals                            | transfer
//  ---------+------------------------------------+--------------------------------
//  input    | start, busy, item (in_t)           | edge with start high, busy low
//  result   | done, result (out_t)               | edge ending the cycle done is high
//  config   | cfg_we, cfg_index, cfg_data        | edge with cfg_we high
//
// One item enters per cycle, busy stays low. Each result is on the result ports
// once its item has passed every stage register and transfers at the next edge;
// the depth is set by the 56-step ratio divider, the 24-step log2 squaring chain
// and the 24-step exp2 multiply chain of the power term in series, the exp term's
// divider and chain run alongside. Reset clears the valid chain and sets the config
// registers to their defaults. The receiver cannot stall the pipeline.
`default_nettype none

module stdp_weight_update_top
	import stdpwu_pkg::*;
(
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        start,
	output logic              busy,
	input  wire  in_t         item,
	input  wire  logic        cfg_we,
	input  wire  logic [2:0]  cfg_index,
	input  wire  logic [31:0] cfg_data,
	output logic              done,
	output out_t              result
);

	cfg_t                cfg_q;
	in_t                 item_s0;
	pipe_t               p0;
	pipe_t               pipe_s [1:N_STAGES];
	logic [N_STAGES:0]   vld_s;
	logic                accept;

	function automatic logic [5:0] lead_one(input logic [55:0] r);
		logic [5:0] m;
		m = '0;
		for (int i = 0; i < 56; i++) begin
			if (r[i]) m = 6'(i);
		end
		return m;
	endfunction

	function automatic pipe_t step(input int k, input pipe_t p, input cfg_t c);
		pipe_t        o;
		logic [31:0]  dmag;
		logic [32:0]  diff;
		logic [31:0]  base;
		logic signed [31:0] amp;
		logic [30:0]  tau;
		logic [36:0]  ediv;
		logic [37:0]  et;
		logic [31:0]  pt;
		logic [30:0]  wdiv;
		logic [62:0]  prod63;
		logic [56:0]  prod57;
		logic [31:0]  xq;
		logic [5:0]   msb;
		logic [31:0]  m32;
		logic [28:0]  labs;
		logic [35:0]  magf;
		logic [31:0]  mag;
		logic [7:0]   n8;
		logic [96:0]  tot;
		logic [62:0]  satv;
		logic [38:0]  dwmag;
		logic [40:0]  sc;
		logic [70:0]  tot2;
		logic [38:0]  mag_n;
		logic         neg;
		logic [31:0]  mw;
		o = p;
		tau = p.dneg ? c.dep_tau : c.pot_tau;
		if (tau == '0) tau = 31'd1;
		ediv = {tau, NORM_SHIFT'(0)};
		wdiv = (c.max_weight == '0) ? 31'd1 : c.max_weight;

		if (k == ST_PREP) begin
			dmag = p.item.interval[31] ? 32'(-p.item.interval) : 32'(p.item.interval);
			o.wmag = p.item.weight_in[31] ? 32'(-p.item.weight_in) : 32'(p.item.weight_in);
			o.gap = dmag <= {1'b0, c.timing_gap};
			o.dneg = p.item.interval[31];
			if (p.item.interval[31]) begin
				base = o.wmag;
				o.mu = c.dep_mu;
				amp = c.dep_amp;
			end else begin
				diff = {2'b0, c.max_weight} - {1'b0, o.wmag};
				base = diff[32] ? 32'(-diff) : diff[31:0];
				o.mu = c.pot_mu;
				amp = c.pot_amp;
			end
			o.amp_neg = amp[31];
			o.amag = amp[31] ? 32'(-amp) : 32'(amp);
			o.e_num = 63'(dmag) * 63'(LOG2E_Q30);
			o.p_r = '0;
			o.p_nq = {base, FRAC'(0)};
		end

		// quotient of the exp argument saturates at 128.0
		if (k == ST_EOVF) begin
			o.e_ovf = {5'b0, p.e_num[62:31]} >= ediv;
			o.e_r = {5'b0, p.e_num[62:31]};
			o.e_nq = p.e_num[30:0];
		end

		if (k >= EDIV_FIRST && k < EDIV_FIRST + EDIV_N) begin
			et = {p.e_r, p.e_nq[30]};
			if (et >= {1'b0, ediv}) begin
				o.e_r = 37'(et - {1'b0, ediv});
				o.e_nq = {p.e_nq[29:0], 1'b1};
			end else begin
				o.e_r = et[36:0];
				o.e_nq = {p.e_nq[29:0], 1'b0};
			end
		end

		if (k >= PDIV_FIRST && k < PDIV_FIRST + PDIV_N) begin
			pt = {p.p_r, p.p_nq[55]};
			if (pt >= {1'b0, wdiv}) begin
				o.p_r = 31'(pt - {1'b0, wdiv});
				o.p_nq = {p.p_nq[54:0], 1'b1};
			end else begin
				o.p_r = pt[30:0];
				o.p_nq = {p.p_nq[54:0], 1'b0};
			end
		end

		// exp2 of minus x: split into integer and fraction toward minus infinity
		if (k == ST_EPREP) begin
			xq = p.e_ovf ? 32'h8000_0000 : {1'b0, p.e_nq};
			o.x_acc = 31'h4000_0000;
			if (xq[23:0] == '0) begin
				o.x_f = '0;
				o.x_rsh = xq[31:24] + 8'(NORM_SHIFT);
			end else begin
				o.x_f = 24'(25'h100_0000 - {1'b0, xq[23:0]});
				o.x_rsh = xq[31:24] + 8'(NORM_SHIFT + 1);
			end
		end

		if (k >= EMUL_FIRST && k < EMUL_FIRST + FRAC) begin
			if (p.x_f[FRAC - 1 - (k - EMUL_FIRST)]) begin
				prod63 = 63'(p.x_acc) * 63'(EXP_C[k - EMUL_FIRST + 1]);
				o.x_acc = prod63[60:30];
			end
		end

		if (k == ST_ESHIFT) begin
			o.expv = (p.x_rsh >= 8'd63) ? '0 : 25'(p.x_acc >> p.x_rsh);
		end

		if (k == ST_AE) begin
			prod57 = 57'(p.amag) * 57'(p.expv);
			o.ae = prod57[56:24];
		end

		if (k == ST_LNORM) begin
			o.r_zero = p.p_nq == '0;
			msb = lead_one(p.p_nq);
			o.l_msb = msb;
			o.l_m = (msb > 6'd30) ? 31'(p.p_nq >> (msb - 6'd30))
			                      : 31'(p.p_nq << (6'd30 - msb));
			o.l_frac = '0;
		end

		// one fraction bit of log2 per squaring
		if (k >= LSQ_FIRST && k < LSQ_FIRST + FRAC) begin
			prod63 = 63'(p.l_m) * 63'(p.l_m);
			m32 = prod63[61:30];
			o.l_frac = {p.l_frac[22:0], m32[31]};
			o.l_m = m32[31] ? m32[31:1] : m32[30:0];
		end

		if (k == ST_LMUL) begin
			o.l_neg = p.l_msb < 6'(FRAC);
			if (o.l_neg)
				labs = {5'(6'(FRAC) - p.l_msb), 24'b0} - {5'b0, p.l_frac};
			else
				labs = {5'(p.l_msb - 6'(FRAC)), p.l_frac};
			o.l_prod = 60'(p.mu) * 60'(labs);
		end

		if (k == ST_PPREP) begin
			magf = p.l_prod[59:24];
			mag = (magf > 36'h0_8000_0000) ? 32'h8000_0000 : magf[31:0];
			n8 = mag[31:24];
			o.y_acc = 31'h4000_0000;
			o.y_sat = 1'b0;
			if (!p.l_neg) begin
				o.y_f = mag[23:0];
				if (n8 >= 8'(NORM_SHIFT)) begin
					o.y_lsh = 1'b1;
					o.y_sh = n8 - 8'(NORM_SHIFT);
					o.y_sat = o.y_sh > 8'd31;
				end else begin
					o.y_lsh = 1'b0;
					o.y_sh = 8'(NORM_SHIFT) - n8;
				end
			end else begin
				o.y_lsh = 1'b0;
				if (mag[23:0] == '0) begin
					o.y_f = '0;
					o.y_sh = n8 + 8'(NORM_SHIFT);
				end else begin
					o.y_f = 24'(25'h100_0000 - {1'b0, mag[23:0]});
					o.y_sh = n8 + 8'(NORM_SHIFT + 1);
				end
			end
		end

		if (k >= PMUL_FIRST && k < PMUL_FIRST + FRAC) begin
			if (p.y_f[FRAC - 1 - (k - PMUL_FIRST)]) begin
				prod63 = 63'(p.y_acc) * 63'(EXP_C[k - PMUL_FIRST + 1]);
				o.y_acc = prod63[60:30];
			end
		end

		if (k == ST_PSHIFT) begin
			if (p.mu == '0)
				o.powv = 63'(1) << FRAC;
			else if (p.r_zero)
				o.powv = '0;
			else if (p.y_sat)
				o.powv = 63'(1) << 62;
			else if (p.y_lsh)
				o.powv = 63'(p.y_acc) << p.y_sh;
			else if (p.y_sh >= 8'd63)
				o.powv = '0;
			else
				o.powv = 63'(p.y_acc) >> p.y_sh;
		end

		if (k == ST_DWLO) o.dw_lo = 65'(p.powv[31:0]) * 65'(p.ae);
		if (k == ST_DWHI) o.dw_hi = 64'(p.powv[62:32]) * 64'(p.ae);

		if (k == ST_SCALE) begin
			tot = {1'b0, p.dw_hi, 32'b0} + 97'(p.dw_lo);
			satv = (tot >= (97'(1) << 62)) ? (63'(1) << 62) : tot[62:0];
			dwmag = satv[62:24];
			sc = p.amp_neg ? (41'(1) << FRAC) - 41'(dwmag) : (41'(1) << FRAC) + 41'(dwmag);
			o.s_neg = sc[40];
			o.s_zero = sc == '0;
			o.smag = sc[40] ? 39'(-sc) : sc[38:0];
		end

		if (k == ST_NMUL) begin
			o.n_lo = 52'(p.wmag) * 52'(p.smag[19:0]);
			o.n_hi = 51'(p.wmag) * 51'(p.smag[38:20]);
		end

		if (k == ST_FINAL) begin
			tot2 = {p.n_hi, 20'b0} + 71'(p.n_lo);
			satv = (tot2 >= (71'(1) << 62)) ? (63'(1) << 62) : tot2[62:0];
			if (p.s_zero) begin
				mag_n = {7'b0, p.wmag};
				neg = p.item.weight_in[31];
			end else begin
				mag_n = satv[62:24];
				neg = p.item.weight_in[31] ^ p.s_neg;
			end
			mw = {1'b0, c.max_weight};
			if (p.gap) begin
				o.res.weight_out = p.item.weight_in;
				o.res.was_changed = 1'b0;
				o.res.was_clipped = 1'b0;
			end else begin
				o.res.was_changed = 1'b1;
				o.res.was_clipped = mag_n > {8'b0, c.max_weight};
				if (o.res.was_clipped)
					o.res.weight_out = p.item.is_inhibitory ? -mw : mw;
				else
					o.res.weight_out = neg ? -mag_n[31:0] : mag_n[31:0];
			end
		end
		return o;
	endfunction

	assign busy = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timing_gap <= '0;
			cfg_q.dep_tau <= 31'd16777216;
			cfg_q.pot_tau <= 31'd16777216;
			cfg_q.dep_amp <= '0;
			cfg_q.pot_amp <= '0;
			cfg_q.max_weight <= 31'd16777216;
			cfg_q.dep_mu <= '0;
			cfg_q.pot_mu <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIMING_GAP: cfg_q.timing_gap <= cfg_data[30:0];
				REG_DEP_TAU:    cfg_q.dep_tau <= cfg_data[30:0];
				REG_POT_TAU:    cfg_q.pot_tau <= cfg_data[30:0];
				REG_DEP_AMP:    cfg_q.dep_amp <= cfg_data;
				REG_POT_AMP:    cfg_q.pot_amp <= cfg_data;
				REG_MAX_WEIGHT: cfg_q.max_weight <= cfg_data[30:0];
				REG_DEP_MU:     cfg_q.dep_mu <= cfg_data[30:0];
				REG_POT_MU:     cfg_q.pot_mu <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[N_STAGES-1:0], accept};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_s0 <= item;
	end

	always_comb begin
		p0 = '0;
		p0.item = item_s0;
	end

	for (genvar k = 0; k < N_STAGES; k++) begin : g_stage
		if (k == 0) begin : g_first
			always_ff @(posedge clk) pipe_s[1] <= step(k, p0, cfg_q);
		end else begin : g_next
			always_ff @(posedge clk) pipe_s[k+1] <= step(k, pipe_s[k], cfg_q);
		end
	end

	assign done = vld_s[N_STAGES];
	assign result = pipe_s[N_STAGES].res;

endmodule

`default_nettype wire

/* rtl/stdpwu_checker.sv */
// stdpwu_checker: port-level checks on the stdp weight update top level,
// bound to it below. Depends on stdpwu_pkg for types and pipeline depth.
`default_nettype none

module stdpwu_checker
	import stdpwu_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire in_t         item,
	input wire logic        done,
	input wire out_t        result
);

	localparam int LAT = N_STAGES + 1;
	localparam int CW = $clog2(LAT + 1);

	logic [CW-1:0] cnt_q;
	logic          armed;

	// edges seen since reset release, so that history is trustworthy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cnt_q != CW'(LAT)) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign armed = cnt_q == CW'(LAT);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		armed |-> (done == $past(start && !busy, LAT)))
		else $error("result strobe does not match input transfer latency");

	a_gap_no_clip: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.was_changed) |-> !result.was_clipped)
		else $error("clip flagged on unchanged weight");

	a_gap_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(armed && done && !result.was_changed) |->
		(result.weight_out == $past(item.weight_in, LAT)))
		else $error("unchanged weight differs from input");

endmodule

bind stdp_weight_update_top stdpwu_checker u_checker (.*);

`default_nettype wire
